### src/cnaw_pkg.sv
`default_nettype none
package cnaw_pkg;
    typedef enum logic [5:0] {
        PH_HEADER   = 6'b000001,
        PH_NAME     = 6'b000010,
        PH_NAME_PAD = 6'b000100,
        PH_DATA     = 6'b001000,
        PH_DATA_PAD = 6'b010000,
        PH_STOP     = 6'b100000
    } t_phase;

    localparam logic [1:0] REG_SELECT_MODE   = 2'd0;
    localparam logic [1:0] REG_TARGET_NAME   = 2'd1;
    localparam logic [1:0] REG_TARGET_LENGTH = 2'd2;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    localparam logic [1:0] ST_WALKING  = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TRAILER  = 2'd2;
    localparam logic [1:0] ST_FOUND    = 2'd3;

    localparam int HEADER_BYTES = 110;
    localparam int TRAILER_LEN  = 10;

    // byte classes made in the front, consumed by the walker
    typedef struct packed {
        logic [7:0] byte_val;
        logic [3:0] hex_val;
        logic [5:0] magic_eq;   // one bit per magic position
        logic [9:0] trail_eq;   // one bit per trailer position
        logic       is_nul;
    } t_cls;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
        return d;
    endfunction
endpackage
`default_nettype wire

### src/cnaw_if.sv
`default_nettype none
interface cnaw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] archive_byte;
    modport source (output valid, output archive_byte, input ready);
    modport sink   (input valid, input archive_byte, output ready);
endinterface

interface cnaw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       last_of_field;
    logic       name_matched;
    logic [1:0] walk_status;
    modport source (output valid, output out_byte, output byte_kind, output last_of_field,
                    output name_matched, output walk_status, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input last_of_field,
                    input name_matched, input walk_status, output ready);
endinterface

interface cnaw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/cnaw_front.sv
`default_nettype none
module cnaw_front
    import cnaw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cnaw_in_if.sink    in_ch,
    output t_cls       o_cls,
    output logic       o_valid,
    input  wire logic  i_ready
);
    // two-entry queue of classified bytes
    t_cls       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_cls       w_cls;
    logic [7:0] w_b;

    localparam logic [47:0] MAGIC = "107070";       // position 0 in low byte
    localparam logic [79:0] TRAIL = "!!!RELIART";

    assign w_b = in_ch.archive_byte;
    always_comb begin
        w_cls.byte_val = w_b;
        w_cls.hex_val  = hex_digit(w_b);
        w_cls.is_nul   = (w_b == 8'd0);
        for (int k = 0; k < 6; k++) w_cls.magic_eq[k] = (w_b == MAGIC[8*k +: 8]);
        for (int k = 0; k < 10; k++) w_cls.trail_eq[k] = (w_b == TRAIL[8*k +: 8]);
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign w_push = in_ch.valid && in_ch.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop = o_valid && i_ready;
    assign o_cls = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cls;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
    end
endmodule
`default_nettype wire

### src/cnaw_back.sv
`default_nettype none
module cnaw_back
    import cnaw_pkg::*;
#(
    parameter int MAX_NAME_BYTES = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cls  i_cls,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire logic  i_select_mode,
    input  wire logic [63:0] i_target_name,
    input  wire logic [3:0]  i_target_length,
    cnaw_out_if.source out_ch
);
    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_nsz, n_nsz, r_fsz, n_fsz, r_acc, n_acc;
    logic [1:0]  r_align;
    logic        r_tm, n_tm, r_gm, n_gm;
    logic [1:0]  r_stat, n_stat;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic [1:0]  r_kind, n_kind;
    logic        r_last, n_last, r_mat, n_mat;
    logic [1:0]  w_next;
    logic [3:0]  w_len;
    logic        w_go;
    logic [7:0]  w_tb;

    assign o_ready = !r_ov || out_ch.ready;
    assign w_go = i_valid && o_ready;
    assign w_next = 2'(r_align + 2'd1);
    assign w_len = (32'(i_target_length) > MAX_NAME_BYTES) ? 4'(MAX_NAME_BYTES)
                                                            : i_target_length;
    assign w_tb = (r_cnt < 32'd8) ? i_target_name[8*r_cnt[2:0] +: 8] : 8'd0;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_nsz = r_nsz; n_fsz = r_fsz; n_acc = r_acc;
        n_tm = r_tm; n_gm = r_gm; n_stat = r_stat;
        n_kind = KIND_OTHER; n_last = 1'b0; n_mat = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                n_cnt = r_cnt + 32'd1;
                if (r_cnt < 32'd6 && !i_cls.magic_eq[r_cnt[2:0]]) begin
                    n_stat = ST_BAD_MAGIC; n_phase = PH_STOP; n_cnt = r_cnt;
                end else begin
                    if ((r_cnt >= 32'd54 && r_cnt <= 32'd61)
                        || (r_cnt >= 32'd94 && r_cnt <= 32'd101)) begin
                        n_acc = {r_acc[27:0], i_cls.hex_val};
                        if (r_cnt == 32'd61) n_fsz = n_acc;
                        if (r_cnt == 32'd101) n_nsz = n_acc;
                    end
                    if (r_cnt >= 32'(HEADER_BYTES - 1)) begin
                        n_cnt = 32'd0; n_tm = 1'b1; n_gm = 1'b1;
                        if (r_nsz == 32'd0) begin
                            n_gm = 1'b0;
                            if (w_next != 2'd0) n_phase = PH_NAME_PAD;
                            else if (r_fsz == 32'd0) n_phase = PH_HEADER;
                            else n_phase = PH_DATA;
                        end else n_phase = PH_NAME;
                    end
                end
            end
            PH_NAME: begin
                if (r_cnt < 32'(TRAILER_LEN)) begin
                    if (!i_cls.trail_eq[r_cnt[3:0]]) n_tm = 1'b0;
                end else if (r_cnt == 32'(TRAILER_LEN) && !i_cls.is_nul) n_tm = 1'b0;
                if (r_cnt < 32'(w_len)) begin
                    if (i_cls.byte_val != w_tb) n_gm = 1'b0;
                end else if (r_cnt == 32'(w_len) && !i_cls.is_nul) n_gm = 1'b0;
                n_kind = i_select_mode ? KIND_OTHER : KIND_NAME;
                n_cnt = r_cnt + 32'd1;
                if (n_cnt == r_nsz) begin
                    n_last = 1'b1;
                    n_mat = n_gm && (r_nsz > 32'(w_len));
                    n_gm = n_mat;
                    if (n_tm && r_nsz > 32'(TRAILER_LEN)) begin
                        n_stat = ST_TRAILER; n_phase = PH_STOP;
                    end else if (i_select_mode && n_mat && r_fsz == 32'd0) begin
                        n_stat = ST_FOUND; n_phase = PH_STOP;
                    end else begin
                        n_cnt = 32'd0;
                        if (w_next != 2'd0) n_phase = PH_NAME_PAD;
                        else if (r_fsz == 32'd0) n_phase = PH_HEADER;
                        else n_phase = PH_DATA;
                    end
                end
            end
            PH_NAME_PAD: begin
                if (w_next == 2'd0) begin
                    n_cnt = 32'd0;
                    n_phase = (r_fsz == 32'd0) ? PH_HEADER : PH_DATA;
                end
            end
            PH_DATA: begin
                n_kind = (!i_select_mode || r_gm) ? KIND_DATA : KIND_OTHER;
                n_cnt = r_cnt + 32'd1;
                if (n_cnt == r_fsz) begin
                    n_last = 1'b1;
                    if (i_select_mode && r_gm) begin
                        n_stat = ST_FOUND; n_phase = PH_STOP;
                    end else begin
                        n_cnt = 32'd0;
                        n_phase = (w_next != 2'd0) ? PH_DATA_PAD : PH_HEADER;
                    end
                end
            end
            PH_DATA_PAD: begin
                if (w_next == 2'd0) begin
                    n_cnt = 32'd0; n_phase = PH_HEADER;
                end
            end
            PH_STOP: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_ob <= i_cls.byte_val; r_kind <= n_kind; r_last <= n_last; r_mat <= n_mat;
            r_cnt <= n_cnt; r_nsz <= n_nsz; r_fsz <= n_fsz; r_acc <= n_acc;
        end
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_cnt <= 32'd0; r_nsz <= 32'd0; r_fsz <= 32'd0;
            r_acc <= 32'd0; r_align <= 2'd0; r_tm <= 1'b1; r_gm <= 1'b1;
            r_stat <= ST_WALKING; r_ov <= 1'b0;
        end else begin
            if (w_go) begin
                r_phase <= n_phase; r_align <= w_next; r_tm <= n_tm; r_gm <= n_gm;
                r_stat <= n_stat; r_ov <= 1'b1;
            end else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.out_byte = r_ob;
    assign out_ch.byte_kind = r_kind;
    assign out_ch.last_of_field = r_last;
    assign out_ch.name_matched = r_mat;
    assign out_ch.walk_status = r_stat;
endmodule
`default_nettype wire

### src/cpio_newc_archive_walker_top.sv
`default_nettype none
// channel | dir | handshake   | payload
// in_ch   | in  | valid/ready | archive_byte[7:0]
// out_ch  | out | valid/ready | out_byte, byte_kind, last_of_field, name_matched, walk_status
// cfg_ch  | in  | valid/ready | index[1:0] (0 select_mode, 1 target_name, 2 target_length), data
//
// One item per cycle while out_ch is ready; bytes pass the front queue, then output register.
// The front classifies each byte (hex value, magic/trailer compares) into a 2-deep queue;
// the back runs the walk state and holds one result in its output register.
// Synchronous active-low reset returns to the header phase with status walking.
// Output stall backs up the queue, then in_ch.ready drops. cfg is always ready.
module cpio_newc_archive_walker_top
    import cnaw_pkg::*;
#(
    parameter int MAX_NAME_BYTES = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cnaw_in_if.sink     in_ch,
    cnaw_out_if.source  out_ch,
    cnaw_cfg_if.sink    cfg_ch
);
    logic        r_sel;
    logic [63:0] r_tname;
    logic [3:0]  r_tlen;
    t_cls        w_cls;
    logic        w_qv, w_qr;

    // config registers
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0; r_tname <= 64'd0; r_tlen <= 4'd1;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_SELECT_MODE:   r_sel <= cfg_ch.data[0];
                REG_TARGET_NAME:   r_tname <= cfg_ch.data;
                REG_TARGET_LENGTH: r_tlen <= cfg_ch.data[3:0];
                default: ;
            endcase
        end
    end

    cnaw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cls(w_cls), .o_valid(w_qv), .i_ready(w_qr)
    );

    cnaw_back #(.MAX_NAME_BYTES(MAX_NAME_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cls(w_cls), .i_valid(w_qv), .o_ready(w_qr),
        .i_select_mode(r_sel), .i_target_name(r_tname), .i_target_length(r_tlen),
        .out_ch(out_ch)
    );

`ifndef NO_ASSERTIONS
    // a name match only ever comes on a final name byte
    a_match_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.name_matched |-> out_ch.last_of_field)
        else $error("name_matched without last_of_field");
    // once stopped, status never changes
    a_stat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && out_ch.valid && $past(out_ch.valid)
        && $past(out_ch.walk_status) != ST_WALKING |-> $stable(out_ch.walk_status))
        else $error("walk status changed after stop");
    // byte kind never takes the unused code
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> out_ch.byte_kind != 2'd3)
        else $error("bad byte kind");
`endif
endmodule
`default_nettype wire
